// File: rtl/core/utf8_stream_decoder_unit_defines.svh
// Assertion macros for the UTF-8 stream decoder.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cond_a implies cond_c at the same clock edge.
`define U8SD_ASSERT_IMPLIES(label, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
    else $error("u8sd implication check failed");
// Check that cond holds at every clock edge outside reset.
`define U8SD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("u8sd invariant check failed");
`else
`define U8SD_ASSERT_IMPLIES(label, cond_a, cond_c)
`define U8SD_ASSERT_ALWAYS(label, cond)
`endif

`endif

// File: rtl/core/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned LeftW  = 2;

  // Lead byte tags, compared against the top bits of the byte
  localparam logic [2:0] Lead2Tag = 3'h6;   // 110xxxxx
  localparam logic [3:0] Lead3Tag = 4'hE;   // 1110xxxx
  localparam logic [4:0] Lead4Tag = 5'h1E;  // 11110xxx

  // Sequence lengths in bytes
  localparam logic [CountW-1:0] Len1 = 3'd1;
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;

  // One decoded result word
  typedef struct packed {
    logic              bad_lead;
    logic [CountW-1:0] byte_count;
    logic [CodeW-1:0]  code_point;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: takes one raw byte per input word and gives one
// result word per completed sequence (code point up to 21 bits and the
// number of bytes used) or per invalid lead byte (bad_lead set, code point
// 0, count 1; the byte is dropped). Lead and 2..4 byte sequences are
// decoded without checks on continuation top bits, overlong forms or range.
// Each byte is taken into an input register and decoded into the output
// register once that register is free or being drained; the result is
// held there until it is taken. A new byte is accepted every cycle while
// the output side keeps up. A full sequence sent back to back gives its
// result once its last byte is decoded.
`default_nettype none

`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [u8sd_pkg::ByteW-1:0]      s_tdata,   // [7:0] data_byte
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [23:0]                          m_tdata,   // [20:0] code_point,
                                                          // [23:21] byte_count
  output logic                                 m_tuser    // [0] bad_lead
);

  import u8sd_pkg::*;

  // Input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  // Decoder state
  logic [LeftW-1:0]  bytes_left;
  logic [CodeW-1:0]  partial_value;
  logic [CountW-1:0] seq_length;
  logic [LeftW-1:0]  bytes_left_next;
  logic [CodeW-1:0]  partial_value_next;
  logic [CountW-1:0] seq_length_next;

  // Decode result
  logic    res_valid;
  result_t res;

  // Output register
  logic    out_valid;
  result_t out_word;

  logic advance;

  // Move the held byte on when the output register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Decode one byte against the open sequence
  always_comb begin
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;
    seq_length_next    = seq_length;
    res_valid          = 1'b0;
    res.bad_lead       = 1'b0;
    res.byte_count     = Len1;
    res.code_point     = '0;
    if (bytes_left == '0) begin
      if (!in_byte[ByteW-1]) begin
        res_valid      = 1'b1;
        res.code_point = {{(CodeW-ByteW){1'b0}}, in_byte};
      end else if (in_byte[7:5] == Lead2Tag) begin
        partial_value_next = {{(CodeW-5){1'b0}}, in_byte[4:0]};
        bytes_left_next    = 2'd1;
        seq_length_next    = Len2;
      end else if (in_byte[7:4] == Lead3Tag) begin
        partial_value_next = {{(CodeW-4){1'b0}}, in_byte[3:0]};
        bytes_left_next    = 2'd2;
        seq_length_next    = Len3;
      end else if (in_byte[7:3] == Lead4Tag) begin
        partial_value_next = {{(CodeW-3){1'b0}}, in_byte[2:0]};
        bytes_left_next    = 2'd3;
        seq_length_next    = Len4;
      end else begin
        res_valid    = 1'b1;
        res.bad_lead = 1'b1;
      end
    end else begin
      // Continuation: shift in the low six bits, top bits ignored
      bytes_left_next    = bytes_left - 2'd1;
      partial_value_next = {partial_value[CodeW-7:0], in_byte[5:0]};
      if (bytes_left == 2'd1) begin
        res_valid          = 1'b1;
        res.code_point     = {partial_value[CodeW-7:0], in_byte[5:0]};
        res.byte_count     = seq_length;
        partial_value_next = '0;
        seq_length_next    = '0;
      end
    end
  end

  // Capture input words
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      partial_value <= '0;
      seq_length    <= '0;
    end else if (advance) begin
      bytes_left    <= bytes_left_next;
      partial_value <= partial_value_next;
      seq_length    <= seq_length_next;
    end
  end

  // Hold or load the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_word.byte_count, out_word.code_point};
  assign m_tuser  = out_word.bad_lead;

  // Checks
  `U8SD_ASSERT_IMPLIES(a_bad_lead_form, m_tvalid && m_tuser,
                       (m_tdata[20:0] == '0) && (m_tdata[23:21] == Len1))
  `U8SD_ASSERT_IMPLIES(a_count_range, m_tvalid,
                       (m_tdata[23:21] >= Len1) && (m_tdata[23:21] <= Len4))
  `U8SD_ASSERT_ALWAYS(a_idle_state, (bytes_left == '0) == (seq_length == '0))
  `U8SD_ASSERT_IMPLIES(a_open_length, bytes_left != '0,
                       seq_length > CountW'(bytes_left))

endmodule

`default_nettype wire
